// ----- sv/imp_pkg.sv -----
// Package for the interval end pair matcher.
// Holds sizes, the in/out word types and the control structs that the
// store, the engine and the top level share. No dependencies.
`default_nettype none

package imp_pkg;

  localparam int MaxPerSet = 32;
  localparam int IdxW      = (MaxPerSet > 1) ? $clog2(MaxPerSet) : 1;
  localparam int CntW      = $clog2(MaxPerSet + 1);
  localparam int EndW      = 32;
  localparam int PosW      = 31;
  localparam int ResIdxW   = 5;
  localparam int IdW       = 6;

  typedef struct packed {
    logic            set_sel;
    logic [PosW-1:0] start_pos;
    logic [PosW-1:0] span;
    logic            last_item;
  } imp_in_t;

  typedef struct packed {
    logic               res_set;
    logic [ResIdxW-1:0] res_index;
    logic [IdW-1:0]     pair_id;
    logic               overflowed;
    logic               res_last;
  } imp_out_t;

  // write port of the end stores
  typedef struct packed {
    logic            en_a;
    logic            en_b;
    logic [IdxW-1:0] addr;
    logic [EndW-1:0] data;
  } imp_wr_t;

  // batch hand-over from the loader to the matching engine
  typedef struct packed {
    logic            start;
    logic [CntW-1:0] cnt_a;
    logic [CntW-1:0] cnt_b;
    logic            drop;
  } imp_ctl_t;

endpackage

`default_nettype wire

// ----- sv/imp_store.sv -----
// End stores for sets A and B: one synchronous memory per set.
// One write port, one shared read address, read data registered.
// Depends on imp_pkg.
`default_nettype none

module imp_store import imp_pkg::*; (
  input  logic            clk_i,
  input  imp_wr_t         wr_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output logic [EndW-1:0] rd_a_o,
  output logic [EndW-1:0] rd_b_o
);

  logic [EndW-1:0] ends_a_mem [MaxPerSet];
  logic [EndW-1:0] ends_b_mem [MaxPerSet];
  logic [EndW-1:0] rd_a_q;
  logic [EndW-1:0] rd_b_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en_a) begin
      ends_a_mem[wr_i.addr] <= wr_i.data;
    end
    rd_a_q <= ends_a_mem[rd_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en_b) begin
      ends_b_mem[wr_i.addr] <= wr_i.data;
    end
    rd_b_q <= ends_b_mem[rd_addr_i];
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

`default_nettype wire

// ----- sv/imp_engine.sv -----
// Matching engine: walks both end stores on every visit of an interval (A
// twice, B once) and emits one result word per interval through an output
// register. Depends on imp_pkg.
`default_nettype none

module imp_engine import imp_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  imp_ctl_t        ctl_i,
  output logic            done_o,
  output logic [IdxW-1:0] rd_addr_o,
  input  logic [EndW-1:0] rd_a_i,
  input  logic [EndW-1:0] rd_b_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output imp_out_t        out_data_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_OWN  = 5'b00010,
    S_CAP  = 5'b00100,
    S_SCAN = 5'b01000,
    S_EMIT = 5'b10000
  } state_e;

  // FLAG marks which A intervals find a partner, IDA and IDB emit ids
  typedef enum logic [2:0] {
    P_FLAG = 3'b001,
    P_IDA  = 3'b010,
    P_IDB  = 3'b100
  } phase_e;

  state_e                state_q, state_d;
  phase_e                phase_q, phase_d;
  logic [IdxW-1:0]       cur_q, cur_d;
  logic [CntW-1:0]       t_q, t_d;
  logic                  p_vld_q, p_vld_d;
  logic [IdxW-1:0]       p_idx_q, p_idx_d;
  logic [EndW-1:0]       own_q, own_d;
  logic [CntW-1:0]       r_q, r_d;
  logic [CntW-1:0]       o_q, o_d;
  logic [CntW-1:0]       m_q, m_d;
  logic [MaxPerSet-1:0]  flag_q, flag_d;
  logic                  out_vld_q, out_vld_d;
  imp_out_t              out_q, out_d;

  logic                  is_b;
  logic [CntW-1:0]       scan_len;
  logic [CntW-1:0]       cnt_own;
  logic [CntW-1:0]       cur_next;
  logic                  elem_last;
  logic                  final_res;
  logic                  a_ok;
  logic                  b_ok;
  logic                  eq_a;
  logic                  eq_b;
  logic                  low;
  logic                  matched;
  logic [CntW-1:0]       pair;

  assign is_b      = (phase_q == P_IDB);
  assign scan_len  = (ctl_i.cnt_a > ctl_i.cnt_b) ? ctl_i.cnt_a : ctl_i.cnt_b;
  assign cnt_own   = is_b ? ctl_i.cnt_b : ctl_i.cnt_a;
  assign cur_next  = CntW'(cur_q) + CntW'(1);
  assign elem_last = (cur_next == cnt_own);
  assign final_res = is_b ? elem_last : (elem_last && (ctl_i.cnt_b == '0));

  assign a_ok = (CntW'(p_idx_q) < ctl_i.cnt_a);
  assign b_ok = (CntW'(p_idx_q) < ctl_i.cnt_b);
  assign eq_a = a_ok && (rd_a_i == own_q);
  assign eq_b = b_ok && (rd_b_i == own_q);
  assign low  = (p_idx_q < cur_q);

  // the k-th interval of an end value pairs if the other set has more than k
  assign matched = (r_q < o_q);
  assign pair    = matched ? CntW'(m_q + r_q + CntW'(1)) : '0;

  always_comb begin
    state_d   = state_q;
    phase_d   = phase_q;
    cur_d     = cur_q;
    t_d       = t_q;
    p_vld_d   = p_vld_q;
    p_idx_d   = p_idx_q;
    own_d     = own_q;
    r_d       = r_q;
    o_d       = o_q;
    m_d       = m_q;
    flag_d    = flag_q;
    out_vld_d = out_vld_q;
    out_d     = out_q;
    rd_addr_o = cur_q;
    done_o    = 1'b0;

    if (out_vld_q && out_ready_i) begin
      out_vld_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (ctl_i.start) begin
          flag_d  = '0;
          cur_d   = '0;
          phase_d = (ctl_i.cnt_a != '0) ? P_FLAG : P_IDB;
          state_d = S_OWN;
        end
      end
      S_OWN: begin
        rd_addr_o = cur_q;
        state_d   = S_CAP;
      end
      S_CAP: begin
        own_d     = is_b ? rd_b_i : rd_a_i;
        rd_addr_o = '0;
        t_d       = CntW'(1);
        p_vld_d   = 1'b1;
        p_idx_d   = '0;
        r_d       = '0;
        o_d       = '0;
        m_d       = '0;
        state_d   = S_SCAN;
      end
      S_SCAN: begin
        if (p_vld_q) begin
          if (is_b) begin
            r_d = r_q + CntW'(eq_b && low);
            o_d = o_q + CntW'(eq_a);
          end else begin
            r_d = r_q + CntW'(eq_a && low);
            o_d = o_q + CntW'(eq_b);
          end
          // matched A intervals with a smaller end come before this id
          m_d = m_q + CntW'(a_ok && flag_q[p_idx_q] && (rd_a_i < own_q));
        end
        if (t_q < scan_len) begin
          rd_addr_o = t_q[IdxW-1:0];
          p_vld_d   = 1'b1;
          p_idx_d   = t_q[IdxW-1:0];
          t_d       = t_q + CntW'(1);
        end else begin
          p_vld_d = 1'b0;
        end
        if (!p_vld_q) begin
          if (phase_q == P_FLAG) begin
            flag_d[cur_q] = matched;
            if (elem_last) begin
              phase_d = P_IDA;
              cur_d   = '0;
            end else begin
              cur_d = cur_next[IdxW-1:0];
            end
            state_d = S_OWN;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_vld_q || out_ready_i) begin
          out_vld_d        = 1'b1;
          out_d.res_set    = is_b;
          out_d.res_index  = ResIdxW'(cur_q);
          out_d.pair_id    = IdW'(pair);
          out_d.overflowed = ctl_i.drop;
          out_d.res_last   = final_res;
          if (final_res) begin
            done_o  = 1'b1;
            state_d = S_IDLE;
          end else begin
            if (elem_last) begin
              phase_d = P_IDB;
              cur_d   = '0;
            end else begin
              cur_d = cur_next[IdxW-1:0];
            end
            state_d = S_OWN;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      phase_q   <= P_FLAG;
      cur_q     <= '0;
      t_q       <= '0;
      p_vld_q   <= 1'b0;
      p_idx_q   <= '0;
      flag_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      cur_q     <= cur_d;
      t_q       <= t_d;
      p_vld_q   <= p_vld_d;
      p_idx_q   <= p_idx_d;
      flag_q    <= flag_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    own_q <= own_d;
    r_q   <= r_d;
    o_q   <= o_d;
    m_q   <= m_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ----- sv/interval_end_pair_matcher.sv -----
// Interval end pair matcher, top level: loader, end stores and matching engine.
// Depends on imp_pkg, imp_store and imp_engine.
//
// Loading takes one word per cycle: each interval's end (start + span - 1)
// goes into the end store of its set at the next free index; words beyond
// 32 per set are dropped and flagged in every result of the batch. The word
// marked last closes the batch; the input then stalls while matching runs.
// For every visit of an interval the engine reads its own end and then scans
// both end stores through their single read port, one index a cycle. A
// intervals are visited twice (partner flag, then pair id) and B intervals
// once; handing over a result waits while the output register is full.
// Results leave through an output register: all A intervals in index order,
// then all B.
`default_nettype none

module interval_end_pair_matcher import imp_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  imp_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output imp_out_t out_data_o
);

  logic            busy_q, busy_d;
  logic            start_q, start_d;
  logic [CntW-1:0] cnt_a_q, cnt_a_d;
  logic [CntW-1:0] cnt_b_q, cnt_b_d;
  logic            drop_q, drop_d;

  logic            in_acc;
  logic            full_a;
  logic            full_b;
  logic [EndW-1:0] end_w;
  imp_wr_t         wr;
  imp_ctl_t        ctl;
  logic            done;
  logic [IdxW-1:0] rd_addr;
  logic [EndW-1:0] rd_a;
  logic [EndW-1:0] rd_b;

  assign in_ready_o = !busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign full_a     = (cnt_a_q >= CntW'(MaxPerSet));
  assign full_b     = (cnt_b_q >= CntW'(MaxPerSet));
  assign end_w      = {1'b0, in_data_i.start_pos} + {1'b0, in_data_i.span} - EndW'(1);

  assign wr.en_a = in_acc && !in_data_i.set_sel && !full_a;
  assign wr.en_b = in_acc && in_data_i.set_sel && !full_b;
  assign wr.addr = in_data_i.set_sel ? cnt_b_q[IdxW-1:0] : cnt_a_q[IdxW-1:0];
  assign wr.data = end_w;

  assign ctl.start = start_q;
  assign ctl.cnt_a = cnt_a_q;
  assign ctl.cnt_b = cnt_b_q;
  assign ctl.drop  = drop_q;

  always_comb begin
    busy_d  = busy_q;
    start_d = 1'b0;
    cnt_a_d = cnt_a_q;
    cnt_b_d = cnt_b_q;
    drop_d  = drop_q;
    if (in_acc) begin
      if (!in_data_i.set_sel) begin
        if (full_a) begin
          drop_d = 1'b1;
        end else begin
          cnt_a_d = cnt_a_q + CntW'(1);
        end
      end else begin
        if (full_b) begin
          drop_d = 1'b1;
        end else begin
          cnt_b_d = cnt_b_q + CntW'(1);
        end
      end
      if (in_data_i.last_item) begin
        busy_d  = 1'b1;
        start_d = 1'b1;
      end
    end
    // last result handed to the output register: open a fresh batch
    if (done) begin
      busy_d  = 1'b0;
      cnt_a_d = '0;
      cnt_b_d = '0;
      drop_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      start_q <= 1'b0;
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      drop_q  <= 1'b0;
    end else begin
      busy_q  <= busy_d;
      start_q <= start_d;
      cnt_a_q <= cnt_a_d;
      cnt_b_q <= cnt_b_d;
      drop_q  <= drop_d;
    end
  end

  imp_store u_store (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_addr_i (rd_addr),
    .rd_a_o    (rd_a),
    .rd_b_o    (rd_b)
  );

  imp_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (ctl),
    .done_o      (done),
    .rd_addr_o   (rd_addr),
    .rd_a_i      (rd_a),
    .rd_b_i      (rd_b),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  a_cnt_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= CntW'(MaxPerSet)) && (cnt_b_q <= CntW'(MaxPerSet)))
    else $error("set count beyond capacity");

  a_batch_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> ((cnt_a_q != '0) || (cnt_b_q != '0)))
    else $error("matching started on an empty batch");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_q |-> busy_q)
    else $error("engine started outside a batch");

  a_pair_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.pair_id <= IdW'(MaxPerSet)))
    else $error("pair id out of range");

endmodule

`default_nettype wire
